/* sv/dkenc_pkg.sv */
`default_nettype none

package dkenc_pkg;

    // ascii characters that carry a valid nucleotide
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_C = 8'h43;
    localparam logic [7:0] CHAR_UPPER_G = 8'h47;
    localparam logic [7:0] CHAR_UPPER_T = 8'h54;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_C = 8'h63;
    localparam logic [7:0] CHAR_LOWER_G = 8'h67;
    localparam logic [7:0] CHAR_LOWER_T = 8'h74;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    localparam int unsigned KMER_WIDTH = 5;
    localparam int unsigned STEP_WIDTH = 4;
    localparam int unsigned CFG_DATA_WIDTH = 5;

    localparam logic [KMER_WIDTH-1:0] KMER_MIN   = 5'd1;
    localparam logic [KMER_WIDTH-1:0] KMER_MAX   = 5'd16;
    localparam logic [KMER_WIDTH-1:0] KMER_RESET = 5'd12;
    localparam logic [STEP_WIDTH-1:0] STEP_MIN   = 4'd1;
    localparam logic [STEP_WIDTH-1:0] STEP_MAX   = 4'd8;
    localparam logic [STEP_WIDTH-1:0] STEP_RESET = 4'd4;

    localparam logic [4:0]  WORD_POS_LAST = 5'h1f;
    localparam logic [3:0]  PACK_POS_LAST = 4'hf;
    localparam logic [31:0] ALL_ONES      = 32'hffff_ffff;

    typedef enum logic [0:0] {
        REG_KMER_LENGTH = 1'b0,
        REG_SAMPLE_STEP = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [1:0] code;
        logic       is_n;
    } base_code_t;

    typedef struct packed {
        logic        word_ready;
        logic [31:0] low_word;
        logic [31:0] high_word;
        logic [31:0] n_word;
        logic        pack_ready;
        logic [31:0] pack_word;
        logic        seed_ready;
        logic        seed_ok;
        logic [31:0] seed_value;
    } result_t;

endpackage

`default_nettype wire

/* sv/dkenc_in_if.sv */
`default_nettype none

interface dkenc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] base_char;
    logic       last;

    modport source (output valid, output base_char, output last, input ready);
    modport sink (input valid, input base_char, input last, output ready);
endinterface

`default_nettype wire

/* sv/dkenc_out_if.sv */
`default_nettype none

interface dkenc_out_if;
    logic        valid;
    logic        ready;
    logic        word_ready;
    logic [31:0] low_word;
    logic [31:0] high_word;
    logic [31:0] n_word;
    logic        pack_ready;
    logic [31:0] pack_word;
    logic        seed_ready;
    logic        seed_ok;
    logic [31:0] seed_value;

    modport source (
        output valid, output word_ready, output low_word, output high_word, output n_word,
        output pack_ready, output pack_word, output seed_ready, output seed_ok,
        output seed_value, input ready
    );
    modport sink (
        input valid, input word_ready, input low_word, input high_word, input n_word,
        input pack_ready, input pack_word, input seed_ready, input seed_ok,
        input seed_value, output ready
    );
endinterface

`default_nettype wire

/* sv/dna_two_bit_kmer_encoder_core.sv */
// Two-bit DNA k-mer encoder. Takes one ASCII base per transaction on bases and
// returns exactly one result transaction per base on results: the packed
// low/high/N words every 32 bases, the 2-bit packed word every 16 bases (both
// flushed by last), and a sampled k-mer seed at every sample_step-th position
// once k bases have been seen. A new base is accepted every clock cycle while
// the result register is free or being read; a base is loaded into the input
// register when accepted, and its result is presented on results from the
// result register. The rate is set by the per-base state update (partial
// words, rolling k-mer, run and phase counters) that feeds back on itself each
// cycle. The user must write kmer_length and sample_step through cfg_write only
// while no base is in flight; the block itself does not enforce this.
`default_nettype none

module dna_two_bit_kmer_encoder_core (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    dkenc_in_if.sink                                     bases,
    dkenc_out_if.source                                  results,
    input  wire logic                                    cfg_write,
    input  wire logic                                    cfg_index,
    input  wire logic [dkenc_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
    import dkenc_pkg::*;

    logic [KMER_WIDTH-1:0] kmer_length_reg;
    logic [STEP_WIDTH-1:0] sample_step_reg;

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;
    logic       res_valid_reg;
    result_t    res_reg;

    logic       stage_go;
    base_code_t decoded;
    result_t    result_comb;

    // the input stage moves on whenever the result register is free or draining
    assign stage_go     = in_valid_reg && (!res_valid_reg || results.ready);
    assign bases.ready  = !in_valid_reg || stage_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg <= KMER_RESET;
            sample_step_reg <= STEP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_KMER_LENGTH: kmer_length_reg <= cfg_data[KMER_WIDTH-1:0];
                REG_SAMPLE_STEP: sample_step_reg <= cfg_data[STEP_WIDTH-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (bases.ready)
                in_valid_reg <= bases.valid;
            if (stage_go)
                res_valid_reg <= 1'b1;
            else if (results.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bases.valid && bases.ready)
        begin
            in_char_reg <= bases.base_char;
            in_last_reg <= bases.last;
        end
        if (stage_go)
            res_reg <= result_comb;
    end

    dkenc_decode u_decode (
        .base_char (in_char_reg),
        .base      (decoded)
    );

    dkenc_stream u_stream (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (stage_go),
        .base        (decoded),
        .last        (in_last_reg),
        .kmer_length (kmer_length_reg),
        .sample_step (sample_step_reg),
        .result      (result_comb)
    );

    assign results.valid      = res_valid_reg;
    assign results.word_ready = res_reg.word_ready;
    assign results.low_word   = res_reg.low_word;
    assign results.high_word  = res_reg.high_word;
    assign results.n_word     = res_reg.n_word;
    assign results.pack_ready = res_reg.pack_ready;
    assign results.pack_word  = res_reg.pack_word;
    assign results.seed_ready = res_reg.seed_ready;
    assign results.seed_ok    = res_reg.seed_ok;
    assign results.seed_value = res_reg.seed_value;

`ifndef SYNTHESIS
    // a full 32-base group always ends a 16-base group too
    a_word_implies_pack: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.word_ready |-> results.pack_ready)
        else $error("word flushed without pack flush");

    a_word_zero_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.word_ready |->
            results.low_word == '0 && results.high_word == '0 && results.n_word == '0)
        else $error("word fields nonzero without word_ready");

    a_seed_zero_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.seed_ready |->
            !results.seed_ok && results.seed_value == '0)
        else $error("seed fields nonzero without seed_ready");
`endif

endmodule

`default_nettype wire

/* sv/dkenc_decode.sv */
`default_nettype none

module dkenc_decode (
    input  wire logic [7:0]           base_char,
    output dkenc_pkg::base_code_t     base
);
    import dkenc_pkg::*;

    always_comb
    begin
        base.code = CODE_A;
        base.is_n = 1'b0;
        unique case (base_char)
            CHAR_UPPER_A, CHAR_LOWER_A: base.code = CODE_A;
            CHAR_UPPER_C, CHAR_LOWER_C: base.code = CODE_C;
            CHAR_UPPER_G, CHAR_LOWER_G: base.code = CODE_G;
            CHAR_UPPER_T, CHAR_LOWER_T: base.code = CODE_T;
            default:                    base.is_n = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

/* sv/dkenc_stream.sv */
`default_nettype none

module dkenc_stream (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                advance,
    input  wire dkenc_pkg::base_code_t               base,
    input  wire logic                                last,
    input  wire logic [dkenc_pkg::KMER_WIDTH-1:0]    kmer_length,
    input  wire logic [dkenc_pkg::STEP_WIDTH-1:0]    sample_step,
    output dkenc_pkg::result_t                       result
);
    import dkenc_pkg::*;

    logic [31:0]           low_acc_reg, low_acc_next;
    logic [31:0]           high_acc_reg, high_acc_next;
    logic [31:0]           n_acc_reg, n_acc_next;
    logic [31:0]           pack_acc_reg, pack_acc_next;
    logic [31:0]           kmer_reg, kmer_next;
    logic [4:0]            run_length_reg, run_length_next;
    logic [4:0]            bases_seen_reg, bases_seen_next;
    logic [2:0]            step_phase_reg, step_phase_next;
    logic [4:0]            word_position_reg, word_position_next;

    logic [KMER_WIDTH-1:0] k_eff;
    logic [STEP_WIDTH-1:0] step_eff;
    logic [3:0]            pack_pos;
    logic [31:0]           low_upd, high_upd, n_upd, pack_upd;
    logic [31:0]           kmer_ins, kmer_upd, kmer_mask;
    logic [2:0]            phase_base;
    logic [3:0]            phase_inc;
    logic                  seed_ready, seed_ok, wrdy, prdy;

    always_comb
    begin
        k_eff = kmer_length;
        if (kmer_length < KMER_MIN)
            k_eff = KMER_MIN;
        else if (kmer_length > KMER_MAX)
            k_eff = KMER_MAX;
        step_eff = sample_step;
        if (sample_step < STEP_MIN)
            step_eff = STEP_MIN;
        else if (sample_step > STEP_MAX)
            step_eff = STEP_MAX;

        pack_pos = word_position_reg[3:0];

        // drop this base's bits into the partial words
        for (int i = 0; i < 32; i++)
        begin
            low_upd[i]  = low_acc_reg[i]  | (base.code[0] & (word_position_reg == 5'(i)));
            high_upd[i] = high_acc_reg[i] | (base.code[1] & (word_position_reg == 5'(i)));
            n_upd[i]    = n_acc_reg[i]    | (base.is_n   & (word_position_reg == 5'(i)));
            kmer_mask[i] = (6'(i) < {k_eff, 1'b0});
        end
        for (int i = 0; i < 16; i++)
        begin
            pack_upd[2*i +: 2] = pack_acc_reg[2*i +: 2]
                               | ((pack_pos == 4'(i)) ? base.code : 2'b00);
            // newest base lands in lane k-1
            kmer_ins[2*i +: 2] = (k_eff == 5'(i + 1)) ? base.code : 2'b00;
        end

        kmer_upd = {2'b00, kmer_reg[31:2]} | kmer_ins;
        if (base.is_n)
        begin
            kmer_next       = '0;
            run_length_next = '0;
        end
        else
        begin
            kmer_next       = kmer_upd;
            run_length_next = (run_length_reg >= k_eff) ? k_eff : run_length_reg + 5'd1;
        end

        bases_seen_next = (bases_seen_reg >= k_eff) ? k_eff : bases_seen_reg + 5'd1;

        // sampling phase; a phase left over from a larger step wraps to zero
        phase_base      = ({1'b0, step_phase_reg} >= step_eff) ? 3'd0 : step_phase_reg;
        phase_inc       = {1'b0, phase_base} + 4'd1;
        seed_ready      = 1'b0;
        step_phase_next = step_phase_reg;
        if (bases_seen_next >= k_eff)
        begin
            seed_ready      = (phase_base == 3'd0);
            step_phase_next = (phase_inc >= step_eff) ? 3'd0 : phase_inc[2:0];
        end
        seed_ok = seed_ready && (run_length_next >= k_eff);

        wrdy = (word_position_reg == WORD_POS_LAST) || last;
        prdy = (pack_pos == PACK_POS_LAST) || last;

        result.word_ready = wrdy;
        result.low_word   = wrdy ? low_upd  : '0;
        result.high_word  = wrdy ? high_upd : '0;
        result.n_word     = wrdy ? n_upd    : '0;
        result.pack_ready = prdy;
        result.pack_word  = prdy ? pack_upd : '0;
        result.seed_ready = seed_ready;
        result.seed_ok    = seed_ok;
        result.seed_value = !seed_ready ? '0 : (seed_ok ? (kmer_next & kmer_mask) : ALL_ONES);

        low_acc_next       = wrdy ? '0 : low_upd;
        high_acc_next      = wrdy ? '0 : high_upd;
        n_acc_next         = wrdy ? '0 : n_upd;
        pack_acc_next      = prdy ? '0 : pack_upd;
        word_position_next = word_position_reg + 5'd1;

        // end of stream: everything restarts
        if (last)
        begin
            low_acc_next       = '0;
            high_acc_next      = '0;
            n_acc_next         = '0;
            pack_acc_next      = '0;
            kmer_next          = '0;
            run_length_next    = '0;
            bases_seen_next    = '0;
            step_phase_next    = '0;
            word_position_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_acc_reg       <= '0;
            high_acc_reg      <= '0;
            n_acc_reg         <= '0;
            pack_acc_reg      <= '0;
            kmer_reg          <= '0;
            run_length_reg    <= '0;
            bases_seen_reg    <= '0;
            step_phase_reg    <= '0;
            word_position_reg <= '0;
        end
        else if (advance)
        begin
            low_acc_reg       <= low_acc_next;
            high_acc_reg      <= high_acc_next;
            n_acc_reg         <= n_acc_next;
            pack_acc_reg      <= pack_acc_next;
            kmer_reg          <= kmer_next;
            run_length_reg    <= run_length_next;
            bases_seen_reg    <= bases_seen_next;
            step_phase_reg    <= step_phase_next;
            word_position_reg <= word_position_next;
        end
    end

`ifndef SYNTHESIS
    // a valid run never outgrows the stream count, both clamp to k together
    a_run_within_seen: assert property (@(posedge clk) disable iff (!rst_n)
        run_length_reg <= bases_seen_reg)
        else $error("run length exceeds bases seen");

    a_seen_within_max: assert property (@(posedge clk) disable iff (!rst_n)
        bases_seen_reg <= KMER_MAX)
        else $error("bases seen exceeds largest k");

    a_run_within_max: assert property (@(posedge clk) disable iff (!rst_n)
        run_length_reg <= KMER_MAX)
        else $error("run length exceeds largest k");
`endif

endmodule

`default_nettype wire

/* verif/kmer_result_checker.sv */
`default_nettype none

module kmer_result_checker
    import dkenc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    dkenc_in_if                            bases,
    dkenc_out_if                           results,
    input  wire logic                      cfg_write,
    input  wire logic                      cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data,
    output int                             mismatch_count,
    output int                             results_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 40;

    logic [KMER_WIDTH-1:0] kmer_setting;
    logic [STEP_WIDTH-1:0] step_setting;

    logic [31:0] low_bits;
    logic [31:0] high_bits;
    logic [31:0] n_bits;
    logic [31:0] packed_codes;
    logic [31:0] rolling_kmer;
    logic [4:0]  valid_run;
    logic [4:0]  stream_count;
    logic [2:0]  sample_phase;
    logic [4:0]  base_index;

    result_t expected_results[$];

    function automatic void clear_stream();
        low_bits     = '0;
        high_bits    = '0;
        n_bits       = '0;
        packed_codes = '0;
        rolling_kmer = '0;
        valid_run    = '0;
        stream_count = '0;
        sample_phase = '0;
        base_index   = '0;
    endfunction

    // advances the encoder state by one base and returns what it should emit
    function automatic result_t predict_base(input logic [7:0] ch, input logic is_last);
        result_t             r;
        logic [4:0]          k;
        logic [3:0]          step;
        logic [31:0]         kmer_mask;
        logic [1:0]          code;
        logic                is_n;
        logic [3:0]          pack_pos;
        logic                sampled;

        r = '0;
        k = (kmer_setting < KMER_MIN) ? KMER_MIN :
            (kmer_setting > KMER_MAX) ? KMER_MAX : kmer_setting;
        step = (step_setting < STEP_MIN) ? STEP_MIN :
               (step_setting > STEP_MAX) ? STEP_MAX : step_setting;
        kmer_mask = (k == KMER_MAX) ? ALL_ONES : ((32'd1 << (2 * k)) - 32'd1);

        code = CODE_A;
        is_n = 1'b0;
        case (ch)
            CHAR_UPPER_A, CHAR_LOWER_A: code = CODE_A;
            CHAR_UPPER_C, CHAR_LOWER_C: code = CODE_C;
            CHAR_UPPER_G, CHAR_LOWER_G: code = CODE_G;
            CHAR_UPPER_T, CHAR_LOWER_T: code = CODE_T;
            default: is_n = 1'b1;
        endcase

        pack_pos = base_index[3:0];
        low_bits[base_index]  = low_bits[base_index] | code[0];
        high_bits[base_index] = high_bits[base_index] | code[1];
        n_bits[base_index]    = n_bits[base_index] | is_n;
        packed_codes[2 * pack_pos +: 2] = packed_codes[2 * pack_pos +: 2] | code;

        if (is_n)
        begin
            rolling_kmer = '0;
            valid_run    = '0;
        end
        else
        begin
            rolling_kmer = (rolling_kmer >> 2) | ({30'd0, code} << (2 * k - 2));
            valid_run    = (valid_run >= k) ? k : valid_run + 5'd1;
        end

        stream_count = (stream_count >= k) ? k : stream_count + 5'd1;
        sampled = 1'b0;
        if (stream_count >= k)
        begin
            // a phase left over from a larger step wraps here
            if ({1'b0, sample_phase} >= step)
                sample_phase = '0;
            sampled = (sample_phase == 3'd0);
            sample_phase = ({1'b0, sample_phase} + 4'd1 >= step) ? 3'd0 : sample_phase + 3'd1;
        end

        if (base_index == WORD_POS_LAST || is_last)
        begin
            r.word_ready = 1'b1;
            r.low_word   = low_bits;
            r.high_word  = high_bits;
            r.n_word     = n_bits;
            low_bits     = '0;
            high_bits    = '0;
            n_bits       = '0;
        end
        if (pack_pos == PACK_POS_LAST || is_last)
        begin
            r.pack_ready = 1'b1;
            r.pack_word  = packed_codes;
            packed_codes = '0;
        end
        if (sampled)
        begin
            r.seed_ready = 1'b1;
            r.seed_ok    = (valid_run >= k);
            r.seed_value = r.seed_ok ? (rolling_kmer & kmer_mask) : ALL_ONES;
        end

        base_index = base_index + 5'd1;
        if (is_last)
            clear_stream();
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : monitor
        result_t want;

        if (!rst_n)
        begin
            kmer_setting = KMER_RESET;
            step_setting = STEP_RESET;
            clear_stream();
            expected_results.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_KMER_LENGTH)
                    kmer_setting = cfg_data[KMER_WIDTH-1:0];
                else
                    step_setting = cfg_data[STEP_WIDTH-1:0];
            end

            if (bases.valid && bases.ready)
                expected_results.push_back(predict_base(bases.base_char, bases.last));

            if (results.valid && results.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: result transaction with nothing expected", $time);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("word_ready", 32'(want.word_ready), 32'(results.word_ready));
                    check_field("low_word",   want.low_word,   results.low_word);
                    check_field("high_word",  want.high_word,  results.high_word);
                    check_field("n_word",     want.n_word,     results.n_word);
                    check_field("pack_ready", 32'(want.pack_ready), 32'(results.pack_ready));
                    check_field("pack_word",  want.pack_word,  results.pack_word);
                    check_field("seed_ready", 32'(want.seed_ready), 32'(results.seed_ready));
                    check_field("seed_ok",    32'(want.seed_ok),    32'(results.seed_ok));
                    check_field("seed_value", want.seed_value, results.seed_value);
                end
            end
        end
        results_outstanding = expected_results.size();
    end

endmodule

`default_nettype wire

/* verif/testbench.sv */
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dkenc_pkg::*;

    localparam int IDLE_LIMIT     = 2000;
    localparam int PHASE_COUNT    = 12;
    localparam int BASES_PER_PHASE = 140;

    localparam logic [7:0] NUCLEOTIDES [8] = '{
        CHAR_UPPER_A, CHAR_UPPER_C, CHAR_UPPER_G, CHAR_UPPER_T,
        CHAR_LOWER_A, CHAR_LOWER_C, CHAR_LOWER_G, CHAR_LOWER_T
    };

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_write;
    logic                      cfg_index;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;
    logic                      sink_ready = 1'b0;

    int mismatch_count;
    int results_outstanding;
    int idle_cycles = 0;
    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 0;

    dkenc_in_if  bases ();
    dkenc_out_if results ();

    assign results.ready = sink_ready;

    dna_two_bit_kmer_encoder_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .bases     (bases),
        .results   (results),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    kmer_result_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .bases               (bases),
        .results             (results),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    always #4 clk = ~clk;

    // result side stalls follow a mode that is redrawn at random whenever its countdown runs out
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(10, 80);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: sink_ready <= 1'b1;
            1: sink_ready <= 1'($urandom_range(0, 1));
            2: sink_ready <= ($urandom_range(0, 3) == 0);
            default: sink_ready <= (stall_left[1:0] != 2'd0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((bases.valid && bases.ready) || (results.valid && results.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_base(input logic [7:0] ch, input logic is_last);
        int gap;

        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if ($urandom_range(0, 15) == 0)
                gap = $urandom_range(13, 40);
            repeat (gap)
            begin
                bases.valid <= 1'b0;
                @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        bases.valid     <= 1'b1;
        bases.base_char <= ch;
        bases.last      <= is_last;
        @(posedge clk);
        while (!bases.ready)
            @(posedge clk);
        burst_left--;
    endtask

    // holds the input off until every outstanding result has come back
    task automatic drain_results();
        bases.valid <= 1'b0;
        @(negedge clk);
        while (results_outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_settings(input logic [CFG_DATA_WIDTH-1:0] k,
                                  input logic [CFG_DATA_WIDTH-1:0] step);
        cfg_write <= 1'b1;
        cfg_index <= REG_KMER_LENGTH;
        cfg_data  <= k;
        @(posedge clk);
        cfg_index <= REG_SAMPLE_STEP;
        cfg_data  <= step;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [7:0] random_base(input int n_pct);
        if ($urandom_range(0, 99) < n_pct)
            return 8'($urandom_range(0, 255));
        return NUCLEOTIDES[3'($urandom_range(0, 7))];
    endfunction

    initial
    begin : stimulus
        logic [CFG_DATA_WIDTH-1:0] k_value;
        logic [CFG_DATA_WIDTH-1:0] step_value;
        int                        n_pct;

        rst_n           <= 1'b0;
        cfg_write       <= 1'b0;
        cfg_index       <= REG_KMER_LENGTH;
        cfg_data        <= '0;
        bases.valid     <= 1'b0;
        bases.base_char <= '0;
        bases.last      <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one seed at the twelfth base, then a flush
        for (int i = 0; i < 12; i++)
            send_base(NUCLEOTIDES[3'(i)], i == 11);

        drain_results();
        write_settings(5'd1, 5'd1);
        for (int i = 0; i < 8; i++)
            send_base(NUCLEOTIDES[3'(i)], 1'b0);
        send_base("N", 1'b0);
        send_base(8'h00, 1'b0);
        send_base(8'hff, 1'b0);
        send_base(CHAR_UPPER_T, 1'b1);
        send_base(CHAR_LOWER_G, 1'b1);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain_results();
            case (phase)
                0: begin k_value = 5'd16; step_value = 5'd8;  end
                1: begin k_value = 5'd31; step_value = 5'd15; end
                2: begin k_value = 5'd0;  step_value = 5'd0;  end
                3: begin k_value = 5'd12; step_value = 5'd4;  end
                4: begin k_value = 5'd17; step_value = 5'd9;  end
                5: begin k_value = 5'd1;  step_value = 5'd8;  end
                6: begin k_value = 5'd16; step_value = 5'd1;  end
                default:
                begin
                    k_value    = 5'($urandom_range(0, 31));
                    step_value = 5'($urandom_range(0, 31));
                end
            endcase
            write_settings(k_value, step_value);
            n_pct = $urandom_range(0, 20);
            for (int i = 0; i < BASES_PER_PHASE; i++)
            begin
                send_base(random_base(n_pct), $urandom_range(0, 59) == 0);
                if ($urandom_range(0, 199) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && results_outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
